### sv/mexp_pkg.sv
`default_nettype none
package mexp_pkg;
    localparam int W = 63;
    localparam int EXP_BITS = 64;
    localparam int CW = $clog2(W + 1);

    typedef logic [W-1:0] t_word;
    typedef logic [CW-1:0] t_cnt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_SCAN,
        ST_MUL,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

### sv/mexp_if.sv
`default_nettype none
interface mexp_in_if;
    logic valid;
    logic ready;
    mexp_pkg::t_word base;
    mexp_pkg::t_word exponent;
    mexp_pkg::t_word modulus;
    modport source(output valid, base, exponent, modulus, input ready);
    modport sink(input valid, base, exponent, modulus, output ready);
endinterface

interface mexp_out_if;
    logic valid;
    logic ready;
    mexp_pkg::t_word power_mod;
    modport source(output valid, power_mod, input ready);
    modport sink(input valid, power_mod, output ready);
endinterface
`default_nettype wire

### sv/modular_exponentiation.sv
`default_nettype none
// Channel   Dir  Words
// i_in      in   base, exponent, modulus
// o_out     out  power_mod
//
// One word is handled in steps: the base is first reduced modulo the modulus,
// then the exponent bits are scanned from the top down, and for every bit from
// the top set bit down the accumulator is squared, then multiplied by the
// reduced base when the bit is set. Each multiplication runs one shift-subtract
// step a cycle in a single modular adder. Reset is synchronous,
// active low, and returns to idle. A finished word waits in the output
// register until taken; a new word is accepted only when idle, and may be
// taken while the previous result still waits.
module modular_exponentiation (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mexp_in_if.sink       i_in,
    mexp_out_if.source    o_out
);
    mexp_pkg::t_state r_state, n_state;
    mexp_pkg::t_word  r_b, n_b, r_m, n_m, r_acc, n_acc, r_x, n_x, r_y, n_y, r_r, n_r;
    logic [mexp_pkg::EXP_BITS-1:0] r_e, n_e;
    mexp_pkg::t_cnt   r_k, n_k;
    logic             r_sq, n_sq, r_started, n_started;
    logic             r_ov, n_ov;
    mexp_pkg::t_word  r_out, n_out;
    logic [6:0]       r_bi, n_bi;

    // Shared unit: doubles r, subtracts m once, optionally adds x and reduces.
    logic [mexp_pkg::W:0] s1, s1r, s2;
    mexp_pkg::t_word      d1, step_r;
    logic                 ybit;

    always_comb begin
        ybit   = r_y[r_k[5:0]];
        s1     = {r_r, 1'b0};
        s1r    = (s1 >= {1'b0, r_m}) ? s1 - {1'b0, r_m} : s1;
        d1     = s1r[mexp_pkg::W-1:0];
        s2     = {1'b0, d1} + (ybit ? {1'b0, r_x} : '0);
        if (s2 >= {1'b0, r_m}) begin
            s2 = s2 - {1'b0, r_m};
        end
        step_r = s2[mexp_pkg::W-1:0];
    end

    always_comb begin
        n_state = r_state; n_b = r_b; n_m = r_m; n_acc = r_acc; n_x = r_x;
        n_y = r_y; n_r = r_r; n_e = r_e; n_k = r_k; n_sq = r_sq;
        n_started = r_started; n_ov = r_ov; n_out = r_out; n_bi = r_bi;
        i_in.ready = (r_state == mexp_pkg::ST_IDLE);
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_m = i_in.modulus;
                    n_e = {1'b0, i_in.exponent};
                    // Base mod modulus by bit-serial restoring reduction.
                    n_x = i_in.base;
                    n_y = '0;
                    n_r = '0;
                    n_b = i_in.base;
                    n_k = mexp_pkg::CW'(mexp_pkg::W - 1);
                    n_started = 1'b0;
                    n_acc = mexp_pkg::W'(1);
                    n_bi = 7'(mexp_pkg::EXP_BITS - 1);
                    n_state = (i_in.modulus == '0) ? mexp_pkg::ST_DONE
                                                   : mexp_pkg::ST_RED;
                    if (i_in.modulus == '0) n_acc = '0;
                end
            end
            mexp_pkg::ST_RED: begin
                // Restoring reduction of the base, one bit a cycle.
                n_r = d1;
                if ({r_r, r_b[r_k[5:0]]} >= {1'b0, r_m}) begin
                    n_r = mexp_pkg::W'({r_r, r_b[r_k[5:0]]} - {1'b0, r_m});
                end else begin
                    n_r = mexp_pkg::W'({r_r, r_b[r_k[5:0]]});
                end
                if (r_k == '0) begin
                    n_b = n_r;
                    n_state = mexp_pkg::ST_SCAN;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            mexp_pkg::ST_SCAN: begin
                if (!r_started && !r_e[r_bi[5:0]]) begin
                    if (r_bi == '0) n_state = mexp_pkg::ST_DONE;
                    n_bi = r_bi - 1'b1;
                end else begin
                    if (!r_started) n_acc = (r_m == mexp_pkg::W'(1)) ? '0 : mexp_pkg::W'(1);
                    n_started = 1'b1;
                    n_x = r_started ? r_acc
                                    : ((r_m == mexp_pkg::W'(1)) ? '0 : mexp_pkg::W'(1));
                    n_y = n_x;
                    n_r = '0;
                    n_sq = 1'b1;
                    n_k = mexp_pkg::CW'(mexp_pkg::W - 1);
                    n_state = mexp_pkg::ST_MUL;
                end
            end
            mexp_pkg::ST_MUL: begin
                n_r = step_r;
                if (r_k != '0) begin
                    n_k = r_k - 1'b1;
                end else begin
                    n_acc = step_r;
                    n_k = mexp_pkg::CW'(mexp_pkg::W - 1);
                    n_r = '0;
                    if (r_sq && r_e[r_bi[5:0]]) begin
                        n_sq = 1'b0;
                        n_x = step_r;
                        n_y = r_b;
                    end else if (r_bi == '0) begin
                        n_state = mexp_pkg::ST_DONE;
                    end else begin
                        n_bi = r_bi - 1'b1;
                        n_state = mexp_pkg::ST_SCAN;
                    end
                end
            end
            mexp_pkg::ST_DONE: begin
                if (!r_ov) begin
                    n_out = r_acc;
                    n_ov = 1'b1;
                    n_state = mexp_pkg::ST_IDLE;
                end
            end
            default: n_state = mexp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
        r_b <= n_b; r_m <= n_m; r_acc <= n_acc; r_x <= n_x; r_y <= n_y;
        r_r <= n_r; r_e <= n_e; r_k <= n_k; r_sq <= n_sq;
        r_started <= n_started; r_out <= n_out; r_bi <= n_bi;
    end

    assign o_out.valid = r_ov;
    assign o_out.power_mod = r_out;
endmodule
`default_nettype wire
